[design/u2c_pkg.sv]
// package for the utf-8 to cp1252 glyph transcoder
// result descriptor type, character codes and the code point lookup tables
// no dependencies
package u2c_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned IdxW = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [7:0] LEAD_LATIN    = 8'hC2;
  localparam logic [7:0] LEAD_LATIN_HI = 8'hC3;
  localparam logic [7:0] LATIN_LO      = 8'hA0;
  localparam logic [7:0] LATIN_HI_OFS  = 8'h40;

  localparam logic [CpW-1:0] CP_ZWJ  = 21'h0200D;
  localparam logic [CpW-1:0] CP_VS15 = 21'h0FE0E;
  localparam logic [CpW-1:0] CP_VS16 = 21'h0FE0F;

  localparam logic [1:0] WORD_SCORE      = 2'd0;
  localparam logic [1:0] WORD_DIFFICULTY = 2'd1;
  localparam logic [1:0] WORD_S          = 2'd2;
  localparam logic [1:0] WORD_P          = 2'd3;

  typedef enum logic [1:0] {
    PRIM_NONE,
    PRIM_BYTE,
    PRIM_ICON,
    PRIM_WORD
  } prim_e;

  typedef struct packed {
    prim_e      kind;
    logic [7:0] byte_val;
    logic [4:0] icon;
    logic [1:0] word_sel;
    logic       term;
  } desc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } byte_hit_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] id;
  } icon_hit_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] sel;
  } word_hit_t;

  function automatic byte_hit_t cp_lookup(logic [CpW-1:0] cp);
    byte_hit_t r;
    r.hit = 1'b1;
    r.val = 8'h00;
    case (cp)
      21'h020AC: r.val = 8'h80;
      21'h0201A: r.val = 8'h82;
      21'h0201E: r.val = 8'h84;
      21'h02026: r.val = 8'h85;
      21'h02020: r.val = 8'h86;
      21'h02021: r.val = 8'h87;
      21'h00160: r.val = 8'h8A;
      21'h02039: r.val = 8'h8B;
      21'h00152: r.val = 8'h8C;
      21'h0017D: r.val = 8'h8E;
      21'h02018: r.val = 8'h91;
      21'h02019: r.val = 8'h92;
      21'h0201C: r.val = 8'h93;
      21'h0201D: r.val = 8'h94;
      21'h02022, 21'h02219: r.val = 8'h95;
      21'h02013: r.val = 8'h96;
      21'h02014: r.val = 8'h97;
      21'h02122: r.val = 8'h99;
      21'h00161: r.val = 8'h9A;
      21'h0203A: r.val = 8'h9B;
      21'h00153: r.val = 8'h9C;
      21'h0017E: r.val = 8'h9E;
      21'h00178: r.val = 8'h9F;
      21'h00192: r.val = 8'h66;
      21'h002C6: r.val = 8'h5E;
      21'h002DC: r.val = 8'h7E;
      21'h0029F: r.val = 8'h4C;
      21'h01D20: r.val = 8'h56;
      21'h02212, 21'h02010, 21'h02011: r.val = 8'h2D;
      21'h02032: r.val = 8'h27;
      21'h02033: r.val = 8'h22;
      21'h02044: r.val = 8'h2F;
      21'h022C5, 21'h02E31: r.val = 8'hB7;
      21'h1F534: r.val = 8'h52;
      21'h1F7E0: r.val = 8'h4F;
      21'h1F7E1: r.val = 8'h59;
      21'h1F7E2: r.val = 8'h47;
      21'h1F535: r.val = 8'h42;
      21'h1F7E3: r.val = 8'h50;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic icon_hit_t icon_lookup(logic [CpW-1:0] cp);
    icon_hit_t r;
    r.hit = 1'b1;
    r.id  = 5'd0;
    case (cp)
      21'h02B50, 21'h02734, 21'h02606, 21'h02728, 21'h1F31F: r.id = 5'd0;
      21'h02764, 21'h1F49E, 21'h1F496: r.id = 5'd1;
      21'h1F6A9: r.id = 5'd2;
      21'h1F3C1: r.id = 5'd3;
      21'h1F511, 21'h1F5DD: r.id = 5'd4;
      21'h1F501: r.id = 5'd5;
      21'h1F4B0, 21'h1FA99: r.id = 5'd6;
      21'h02694, 21'h1F47E: r.id = 5'd7;
      21'h0231A, 21'h023F0: r.id = 5'd8;
      21'h023F3, 21'h023F1: r.id = 5'd9;
      21'h1F6B6: r.id = 5'd10;
      21'h1F465: r.id = 5'd11;
      21'h1F6AA: r.id = 5'd12;
      21'h1F4CD, 21'h1F5FA: r.id = 5'd13;
      21'h1F480: r.id = 5'd14;
      21'h1F4A3: r.id = 5'd15;
      21'h1F680: r.id = 5'd16;
      21'h1F4BE, 21'h1F4DD: r.id = 5'd17;
      21'h025A2, 21'h025CB: r.id = 5'd18;
      21'h025A3: r.id = 5'd19;
      21'h025CF: r.id = 5'd20;
      21'h025FC, 21'h025A0, 21'h025AA: r.id = 5'd21;
      21'h025FB, 21'h025A1, 21'h025AB: r.id = 5'd22;
      21'h0258C: r.id = 5'd23;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic word_hit_t word_lookup(logic [CpW-1:0] cp);
    word_hit_t r;
    r.hit = 1'b1;
    r.sel = WORD_SCORE;
    case (cp)
      21'h1F4AF: r.sel = WORD_SCORE;
      21'h02696: r.sel = WORD_DIFFICULTY;
      21'h1F162: r.sel = WORD_S;
      21'h1F15F: r.sel = WORD_P;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [IdxW-1:0] word_len(logic [1:0] sel);
    logic [IdxW-1:0] n;
    case (sel)
      WORD_SCORE:      n = 4'd5;
      WORD_DIFFICULTY: n = 4'd10;
      WORD_S:          n = 4'd3;
      WORD_P:          n = 4'd3;
      default:         n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(logic [1:0] sel, logic [IdxW-1:0] pos);
    logic [79:0] txt;
    logic [79:0] sh;
    case (sel)
      WORD_SCORE:      txt = {"Score", 40'h0};
      WORD_DIFFICULTY: txt = "Difficulty";
      WORD_S:          txt = {"(S)", 56'h0};
      WORD_P:          txt = {"(P)", 56'h0};
      default:         txt = '0;
    endcase
    sh = txt << {pos, 3'b000};
    return sh[79:72];
  endfunction

endpackage

[design/u2c_decode.sv]
// utf-8 decoder stage: sequence state, ascii rules, latin and table lookups
// produces one registered result descriptor per item
// depends on u2c_pkg
module u2c_decode import u2c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       desc_valid_o,
  output desc_t      desc_o,
  input  logic       desc_pop_i
);

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     tails_q, tails_d;
  logic [7:0]     lead_q, lead_d;
  logic           skip_q, skip_d;
  logic           desc_valid_q, desc_valid_d;
  desc_t          desc_q, desc_d;

  logic           accept;
  logic           handled;
  logic           ended;
  logic [CpW-1:0] acc_shift;
  byte_hit_t      cp_hit;
  icon_hit_t      icon_hit;
  word_hit_t      word_hit;

  assign in_ready_o   = !desc_valid_q || desc_pop_i;
  assign accept       = in_valid_i && in_ready_o;
  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

  assign acc_shift = {acc_q[CpW-7:0], in_byte_i[5:0]};
  assign cp_hit    = cp_lookup(acc_shift);
  assign icon_hit  = icon_lookup(acc_shift);
  assign word_hit  = word_lookup(acc_shift);

  always_comb begin
    acc_d   = acc_q;
    tails_d = tails_q;
    lead_d  = lead_q;
    skip_d  = skip_q;
    desc_d  = '{kind: PRIM_NONE, byte_val: 8'h00, icon: 5'd0, word_sel: WORD_SCORE,
                term: 1'b0};
    handled = 1'b0;
    ended   = 1'b0;

    if (tails_q != 2'd0) begin
      if (in_byte_i[7:6] == 2'b10) begin
        handled = 1'b1;
        acc_d   = acc_shift;
        tails_d = tails_q - 2'd1;
        if (tails_q == 2'd1) begin
          lead_d = 8'h00;
          acc_d  = '0;
          if (lead_q == LEAD_LATIN && in_byte_i >= LATIN_LO) begin
            desc_d.kind = PRIM_BYTE;
            case (in_byte_i)
              8'hA0: desc_d.byte_val = CH_SPACE;
              8'hA6: desc_d.byte_val = 8'h7C;
              8'hA8: desc_d.byte_val = 8'h22;
              8'hAF: desc_d.byte_val = 8'h2D;
              8'hB4: desc_d.byte_val = 8'h27;
              8'hB8: desc_d.byte_val = 8'h2C;
              8'hA4, 8'hAC, 8'hAD: desc_d.kind = PRIM_NONE;
              default: desc_d.byte_val = in_byte_i;
            endcase
          end else if (lead_q == LEAD_LATIN_HI) begin
            desc_d.kind     = PRIM_BYTE;
            desc_d.byte_val = in_byte_i + LATIN_HI_OFS;
          end else if (acc_shift == CP_ZWJ || acc_shift == CP_VS15 ||
                       acc_shift == CP_VS16) begin
            desc_d.kind = PRIM_NONE;
          end else if (cp_hit.hit) begin
            desc_d.kind     = PRIM_BYTE;
            desc_d.byte_val = cp_hit.val;
          end else if (icon_hit.hit) begin
            desc_d.kind = PRIM_ICON;
            desc_d.icon = icon_hit.id;
          end else if (word_hit.hit) begin
            desc_d.kind     = PRIM_WORD;
            desc_d.word_sel = word_hit.sel;
          end
        end
      end else begin
        tails_d = 2'd0;
        lead_d  = 8'h00;
        acc_d   = '0;
      end
    end

    if (!handled && skip_q) begin
      skip_d = 1'b0;
      if (in_byte_i == CH_LF) begin
        handled = 1'b1;
      end
    end

    if (!handled) begin
      if (in_byte_i == CH_NUL) begin
        desc_d.term = 1'b1;
        ended       = 1'b1;
      end else if (!in_byte_i[7]) begin
        case (in_byte_i)
          CH_TAB: begin
            desc_d.kind     = PRIM_BYTE;
            desc_d.byte_val = CH_SPACE;
          end
          CH_LF: begin
            desc_d.kind     = PRIM_BYTE;
            desc_d.byte_val = CH_LF;
          end
          CH_CR: begin
            desc_d.kind     = PRIM_BYTE;
            desc_d.byte_val = CH_LF;
            skip_d          = 1'b1;
          end
          default: begin
            if (in_byte_i >= CH_SPACE && in_byte_i != CH_DEL) begin
              desc_d.kind     = PRIM_BYTE;
              desc_d.byte_val = in_byte_i;
            end
          end
        endcase
      end else if (in_byte_i[7:5] == 3'b110) begin
        acc_d   = {16'h0, in_byte_i[4:0]};
        tails_d = 2'd1;
        lead_d  = in_byte_i;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        acc_d   = {17'h0, in_byte_i[3:0]};
        tails_d = 2'd2;
        lead_d  = in_byte_i;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        acc_d   = {18'h0, in_byte_i[2:0]};
        tails_d = 2'd3;
        lead_d  = in_byte_i;
      end
    end

    if (!ended && final_byte_i) begin
      desc_d.term = 1'b1;
      ended       = 1'b1;
    end

    if (ended) begin
      acc_d   = '0;
      tails_d = 2'd0;
      lead_d  = 8'h00;
      skip_d  = 1'b0;
    end
  end

  always_comb begin
    desc_valid_d = desc_valid_q;
    if (accept) begin
      desc_valid_d = 1'b1;
    end else if (desc_pop_i) begin
      desc_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      tails_q      <= 2'd0;
      lead_q       <= 8'h00;
      skip_q       <= 1'b0;
      desc_valid_q <= 1'b0;
    end else begin
      desc_valid_q <= desc_valid_d;
      if (accept) begin
        acc_q   <= acc_d;
        tails_q <= tails_d;
        lead_q  <= lead_d;
        skip_q  <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  a_lead_with_tails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tails_q == 2'd0) == (lead_q == 8'h00))
    else $error("lead byte and pending tail count disagree");

  a_skip_no_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> tails_q == 2'd0)
    else $error("lf skip pending inside a sequence");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_byte_i == CH_NUL || final_byte_i) |=>
      tails_q == 2'd0 && acc_q == '0 && !skip_q)
    else $error("state not cleared at end of text");

endmodule

[design/u2c_emit.sv]
// result expander: walks one descriptor into its results into the output register
// word expansions hold the descriptor until their last character is loaded
// depends on u2c_pkg
module u2c_emit import u2c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  input  desc_t      desc_i,
  output logic       desc_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_icon_o,
  output logic [4:0] icon_id_o,
  output logic       is_terminator_o,
  output logic       last_of_run_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_icon_q;
  logic [4:0]      out_id_q;
  logic            out_term_q;
  logic            out_last_q;

  logic [IdxW-1:0] prim_cnt;
  logic [IdxW-1:0] total;
  logic            out_free;
  logic            load;
  logic            last;
  logic [7:0]      res_byte;
  logic            res_icon;
  logic [4:0]      res_id;
  logic            res_term;

  always_comb begin
    case (desc_i.kind)
      PRIM_BYTE: prim_cnt = 4'd1;
      PRIM_ICON: prim_cnt = 4'd1;
      PRIM_WORD: prim_cnt = word_len(desc_i.word_sel);
      default:   prim_cnt = 4'd0;
    endcase
  end

  assign total    = prim_cnt + {3'b000, desc_i.term};
  assign last     = (idx_q == total - 4'd1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    res_byte = 8'h00;
    res_icon = 1'b0;
    res_id   = 5'd0;
    res_term = 1'b0;
    if (idx_q < prim_cnt) begin
      case (desc_i.kind)
        PRIM_BYTE: res_byte = desc_i.byte_val;
        PRIM_ICON: begin
          res_icon = 1'b1;
          res_id   = desc_i.icon;
        end
        PRIM_WORD: res_byte = word_char(desc_i.word_sel, idx_q);
        default: ;
      endcase
    end else begin
      res_term = 1'b1;
    end
  end

  always_comb begin
    load       = 1'b0;
    desc_pop_o = 1'b0;
    idx_d      = idx_q;
    if (desc_valid_i && out_free) begin
      if (total == 4'd0) begin
        desc_pop_o = 1'b1;
      end else begin
        load = 1'b1;
        if (last) begin
          desc_pop_o = 1'b1;
          idx_d      = 4'd0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
    end
    out_valid_d = out_free ? load : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= res_byte;
      out_icon_q <= res_icon;
      out_id_q   <= res_id;
      out_term_q <= res_term;
      out_last_q <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign is_icon_o       = out_icon_q;
  assign icon_id_o       = out_id_q;
  assign is_terminator_o = out_term_q;
  assign last_of_run_o   = out_last_q;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 4'd0 |-> desc_valid_i && idx_q < total)
    else $error("expansion index outside the current item");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_term_q |-> out_last_q)
    else $error("terminator not last result of its item");

  a_icon_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_icon_q |-> out_byte_q == 8'h00 && !out_term_q)
    else $error("icon result carries byte or terminator");

endmodule

[design/utf8_to_cp1252_glyph_transcoder.sv]
// utf-8 to cp1252 glyph transcoder, top level
// items are registered as descriptors, then expanded into the output register
// throughput: one item per cycle while the output is ready and items have one result;
//   longer items hold the expander for all results (up to 11, word plus terminator)
// reset: asynchronous, clears decoder sequence state, expander index and valid flags
// depends on u2c_pkg, u2c_decode, u2c_emit
module utf8_to_cp1252_glyph_transcoder import u2c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_icon_o,
  output logic [4:0] icon_id_o,
  output logic       is_terminator_o,
  output logic       last_of_run_o
);

  logic  desc_valid;
  logic  desc_pop;
  desc_t desc;

  u2c_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_pop_i   (desc_pop)
  );

  u2c_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_valid_i    (desc_valid),
    .desc_i          (desc),
    .desc_pop_o      (desc_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_icon_o       (is_icon_o),
    .icon_id_o       (icon_id_o),
    .is_terminator_o (is_terminator_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
